// ===== hw/rtl/weekly_clock_with_alarms_unit_assert.svh =====
// Assertion macros shared by the clock unit files.
// Both expect signals named clk and rst in the enclosing module.
`ifndef WEEKLY_CLOCK_WITH_ALARMS_UNIT_ASSERT_SVH
`define WEEKLY_CLOCK_WITH_ALARMS_UNIT_ASSERT_SVH

// same-cycle implication
`define WCWA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wcwa assertion failed");

// next-cycle implication
`define WCWA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wcwa assertion failed");

`endif

// ===== hw/rtl/wcwa_pkg.sv =====
package wcwa_pkg;

  localparam int ALARM_SLOTS_DEF = 7;

  localparam logic [19:0] WEEK_SECS = 20'd604800;
  // 49710 days of 86400 seconds
  localparam logic [31:0] ROLL_LIMIT = 32'd4294944000;

  localparam int DIV_QW = 13;

  // register index decode (bit 2 of the byte address)
  localparam logic CFG_IDX_ALARM_COUNT = 1'b0;

  typedef enum logic [2:0] {
    FN_TICK,
    FN_SET_FIELDS,
    FN_SET_RAW,
    FN_ALARM_FIELDS,
    FN_ALARM_RAW,
    FN_SNOOZE_ARM,
    FN_SNOOZE_CLR
  } func_t;

  typedef enum logic [1:0] {
    DIV_WEEK,
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN
  } div_sel_t;

  typedef struct packed {
    logic     start;
    div_sel_t sel;
  } div_req_t;

  typedef struct packed {
    logic we;
    logic re;
  } ram_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_AMOD,
    S_WEEK,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_WALK_RD,
    S_WALK_CMP,
    S_OUT
  } state_t;

  function automatic logic [19:0] field_sum(input logic [2:0] d, input logic [4:0] h,
                                            input logic [5:0] m, input logic [5:0] s);
    return 20'(s) + 20'(m) * 20'd60 + 20'(h) * 20'd3600 + 20'(d) * 20'd86400;
  endfunction

  function automatic logic [31:0] div_divisor(input div_sel_t sel);
    logic [31:0] r;
    case (sel)
      DIV_WEEK: r = 32'd604800;
      DIV_DAY:  r = 32'd86400;
      DIV_HOUR: r = 32'd3600;
      DIV_MIN:  r = 32'd60;
      default:  r = 32'd60;
    endcase
    return r;
  endfunction

  // 2^32 / divisor, rounded down
  function automatic logic [31:0] div_recip(input div_sel_t sel);
    logic [31:0] r;
    case (sel)
      DIV_WEEK: r = 32'd7101;
      DIV_DAY:  r = 32'd49710;
      DIV_HOUR: r = 32'd1193046;
      DIV_MIN:  r = 32'd71582788;
      default:  r = 32'd71582788;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/wcwa_div.sv =====
`include "weekly_clock_with_alarms_unit_assert.svh"

module wcwa_div (
  input  logic                    clk,
  input  logic                    rst,
  input  wcwa_pkg::div_req_t      req,
  input  logic [31:0]             dividend,
  output logic                    busy,
  output logic                    done,
  output logic [wcwa_pkg::DIV_QW-1:0] quo,
  output logic [31:0]             rem
);
  import wcwa_pkg::*;

  logic [31:0] x;
  logic [31:0] dv;
  logic [31:0] recip;
  logic [31:0] qe;
  logic [63:0] prod;
  logic [1:0]  step;
  logic        ge;

  // scaled reciprocal gives a quotient low by at most one
  assign prod = 64'(x) * 64'(recip);
  assign ge   = rem >= dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == 2'd0);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (step == 2'd0)) begin
        busy <= 1'b0;
      end
    end
  end

  // estimate, back-multiply, then one correction step
  always_ff @(posedge clk) begin
    if (req.start) begin
      x     <= dividend;
      dv    <= div_divisor(req.sel);
      recip <= div_recip(req.sel);
      step  <= 2'd2;
    end else if (busy) begin
      case (step)
        2'd2: qe <= prod[63:32];
        2'd1: begin
          rem <= x - qe * dv;
          quo <= qe[DIV_QW-1:0];
        end
        default: begin
          if (ge) begin
            rem <= rem - dv;
            quo <= quo + DIV_QW'(1);
          end
        end
      endcase
      step <= step - 2'd1;
    end
  end

  `WCWA_ASSERT_NXT(a_start_busy, req.start, busy)
  `WCWA_ASSERT_NXT(a_last_done, busy && (step == 2'd0) && !req.start, done && !busy)
  `WCWA_ASSERT_IMP(a_done_idle, done, !busy)

endmodule

// ===== hw/rtl/wcwa_alarm_ram.sv =====
module wcwa_alarm_ram #(
  parameter int SLOTS = wcwa_pkg::ALARM_SLOTS_DEF,
  parameter int IDX_W = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  wcwa_pkg::ram_req_t req,
  input  logic [IDX_W-1:0]   waddr,
  input  logic [19:0]        wdata,
  input  logic [IDX_W-1:0]   raddr,
  output logic [19:0]        rdata
);
  import wcwa_pkg::*;

  logic [19:0]      mem [SLOTS];
  logic [SLOTS-1:0] valid;
  logic [19:0]      rd_q;
  logic             rd_valid;

  // unwritten slots read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[waddr] <= wdata;
    end
    if (req.re) begin
      rd_q     <= mem[raddr];
      rd_valid <= valid[raddr];
    end
  end

  assign rdata = rd_valid ? rd_q : 20'd0;

endmodule

// ===== hw/rtl/weekly_clock_with_alarms_unit.sv =====
// Each item runs through the sequencer in turn: four reciprocal divides (week, day, hour,
// minute), then a walk of the N active alarm slots, N = min of alarm_count and ALARM_SLOTS,
// each slot read from the alarm RAM (registered read) and compared. A raw alarm write first
// adds one more divide to reduce its time to the week. One item at a time: no new item is
// accepted until its result is loaded. A stalled result holds the sequencer.
// Reset (rst, synchronous): count, snooze, alarm_count and alarm valid bits cleared.
`include "weekly_clock_with_alarms_unit_assert.svh"

module weekly_clock_with_alarms_unit #(
  parameter int ALARM_SLOTS = wcwa_pkg::ALARM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input item stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // slot[2:0], day_in[5:3], hour_in[10:6], minute_in[16:11], second_in[22:17],
  // raw_in[54:23], zero pad[55]
  input  logic [55:0] s_tdata,
  // func[2:0]
  input  logic [2:0]  s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // raw_count[31:0], second_out[37:32], minute_out[43:38], hour_out[48:44],
  // weekday_out[51:49], alarm_hit[52], zero pad[55:53]
  output logic [55:0] m_tdata,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wcwa_pkg::*;

  localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int CNT_W = $clog2(ALARM_SLOTS + 1);

  state_t state, state_next;

  // latched command
  logic [2:0]  func_q;
  logic [2:0]  slot_q;
  logic [2:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  min_q;
  logic [5:0]  sec_q;
  logic [31:0] raw_q;

  // architectural state outside the alarm RAM
  logic [31:0] count, count_next;
  logic [31:0] snooze_time;
  logic        snooze_armed;
  logic [2:0]  alarm_count;

  // decomposed time of the current item
  logic [19:0] week;
  logic [2:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic        hit;
  logic [CNT_W-1:0] idx;

  // result register
  logic [31:0] out_raw;
  logic [5:0]  out_sec;
  logic [5:0]  out_min;
  logic [4:0]  out_hour;
  logic [2:0]  out_day;
  logic        out_hit;

  // divider hookup
  div_req_t              div_req;
  logic [31:0]           div_dividend;
  logic                  div_busy;
  logic                  div_done;
  logic [DIV_QW-1:0]     div_quo;
  logic [31:0]           div_rem;

  // alarm RAM hookup
  ram_req_t          ram_req;
  logic [IDX_W-1:0]  ram_waddr;
  logic [19:0]       ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [19:0]       ram_rdata;

  logic [19:0] fsum;
  logic [19:0] alarm_f_val;
  logic        slot_ok;
  logic [4:0]  n_act;
  logic        walk_more;
  logic        in_acc;
  logic        out_load;
  logic        cfg_wr;

  assign in_acc   = s_tvalid && s_tready;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // field-form time and its week-reduced form for alarm slots
  assign fsum        = field_sum(day_q, hour_q, min_q, sec_q);
  assign alarm_f_val = (fsum >= WEEK_SECS) ? (fsum - WEEK_SECS) : fsum;
  assign slot_ok     = {29'd0, slot_q} < 32'(ALARM_SLOTS);

  // alarm_count above the slot count compares all slots
  assign n_act     = (5'(alarm_count) > 5'(ALARM_SLOTS)) ? 5'(ALARM_SLOTS) : 5'(alarm_count);
  assign walk_more = 5'(idx) < n_act;

  always_comb begin
    case (func_q)
      FN_TICK:       count_next = count + 32'd1;
      FN_SET_FIELDS: count_next = {12'd0, fsum};
      FN_SET_RAW:    count_next = raw_q;
      default:       count_next = count;
    endcase
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_acc) state_next = S_EXEC;
      S_EXEC:     state_next = (func_q == FN_ALARM_RAW) ? S_AMOD : S_WEEK;
      S_AMOD:     if (div_done) state_next = S_WEEK;
      S_WEEK:     if (div_done) state_next = S_DAY;
      S_DAY:      if (div_done) state_next = S_HOUR;
      S_HOUR:     if (div_done) state_next = S_MIN;
      S_MIN:      if (div_done) state_next = S_WALK_RD;
      S_WALK_RD:  state_next = walk_more ? S_WALK_CMP : S_OUT;
      S_WALK_CMP: state_next = S_WALK_RD;
      S_OUT:      if (out_load) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  // After the first divide, each divide is launched in the cycle that finishes the previous
  // one; from the day divide on, the divider's remainder feeds the next stage of the breakdown.
  always_comb begin
    s_tready     = (state == S_IDLE);
    div_req      = '0;
    div_dividend = div_rem;
    ram_req      = '0;
    ram_waddr    = IDX_W'(slot_q);
    ram_wdata    = alarm_f_val;
    ram_raddr    = idx[IDX_W-1:0];
    case (state)
      S_EXEC: begin
        div_req.start = 1'b1;
        div_req.sel   = DIV_WEEK;
        if (func_q == FN_ALARM_RAW) begin
          div_dividend = raw_q;
        end else begin
          div_dividend = count_next;
          ram_req.we   = (func_q == FN_ALARM_FIELDS) && slot_ok;
        end
      end
      S_AMOD: begin
        ram_wdata = div_rem[19:0];
        if (div_done) begin
          ram_req.we    = slot_ok;
          div_req.start = 1'b1;
          div_req.sel   = DIV_WEEK;
          div_dividend  = count;
        end
      end
      S_WEEK: begin
        div_dividend = {12'd0, div_rem[19:0]};
        if (div_done) begin
          div_req.start = 1'b1;
          div_req.sel   = DIV_DAY;
        end
      end
      S_DAY: begin
        if (div_done) begin
          div_req.start = 1'b1;
          div_req.sel   = DIV_HOUR;
        end
      end
      S_HOUR: begin
        if (div_done) begin
          div_req.start = 1'b1;
          div_req.sel   = DIV_MIN;
        end
      end
      S_WALK_RD: ram_req.re = walk_more;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_q <= s_tuser;
      slot_q <= s_tdata[2:0];
      day_q  <= s_tdata[5:3];
      hour_q <= s_tdata[10:6];
      min_q  <= s_tdata[16:11];
      sec_q  <= s_tdata[22:17];
      raw_q  <= s_tdata[54:23];
    end
  end

  // count and snooze
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      snooze_time  <= '0;
      snooze_armed <= 1'b0;
    end else begin
      if (state == S_EXEC) begin
        count <= count_next;
        if (func_q == FN_SNOOZE_ARM) begin
          snooze_time  <= raw_q;
          snooze_armed <= 1'b1;
        end else if (func_q == FN_SNOOZE_CLR) begin
          snooze_armed <= 1'b0;
        end
      end
      // day count at 49710 or beyond: fold back into the first week
      if ((state == S_WEEK) && div_done && (count >= ROLL_LIMIT)) begin
        count <= div_rem;
      end
    end
  end

  // time breakdown and alarm walk
  always_ff @(posedge clk) begin
    if ((state == S_WEEK) && div_done) begin
      week <= div_rem[19:0];
    end
    if ((state == S_DAY) && div_done) begin
      day_r <= div_quo[2:0];
    end
    if ((state == S_HOUR) && div_done) begin
      hour_r <= div_quo[4:0];
    end
    if ((state == S_MIN) && div_done) begin
      min_r <= div_quo[5:0];
      sec_r <= div_rem[5:0];
      idx   <= '0;
      // snooze due at its time or one second before
      hit   <= snooze_armed && ((snooze_time == count) || (snooze_time == count + 32'd1));
    end
    if (state == S_WALK_CMP) begin
      hit <= hit || (ram_rdata == week) || ({1'b0, ram_rdata} == {1'b0, week} + 21'd1);
      idx <= idx + CNT_W'(1);
    end
  end

  // result register: decouples the sequencer from the output side
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_raw  <= count;
      out_sec  <= sec_r;
      out_min  <= min_r;
      out_hour <= hour_r;
      out_day  <= day_r;
      out_hit  <= hit;
    end
  end

  assign m_tdata = {3'd0, out_hit, out_day, out_hour, out_min, out_sec, out_raw};

  // config register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_count <= '0;
    end else if (cfg_wr && (paddr[2] == CFG_IDX_ALARM_COUNT)) begin
      alarm_count <= pwdata[2:0];
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_ALARM_COUNT) ? {29'd0, alarm_count} : 32'd0;

  wcwa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  wcwa_alarm_ram #(
    .SLOTS (ALARM_SLOTS),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .rst   (rst),
    .req   (ram_req),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `WCWA_ASSERT_IMP(a_div_start_free, div_req.start, !div_busy)
  `WCWA_ASSERT_IMP(a_ram_no_overlap, ram_req.we, !ram_req.re)
  `WCWA_ASSERT_IMP(a_out_min_sec, m_tvalid, (out_sec < 6'd60) && (out_min < 6'd60))
  `WCWA_ASSERT_IMP(a_out_hour_day, m_tvalid, (out_hour < 5'd24) && (out_day < 3'd7))
  `WCWA_ASSERT_IMP(a_out_rolled, m_tvalid, out_raw < ROLL_LIMIT)

endmodule
